/* design/vli_pkg.sv */
// ----------------------------------------------------------------------------
// vli_pkg
// Shared widths, constants and inter-module types for the vector length unit.
// ----------------------------------------------------------------------------
package vli_pkg;

  localparam int COMP_W      = 32;              // signed 16.16 component
  localparam int MAG_W       = 32;              // magnitude of a component
  localparam int SUM_W       = 64;              // sum of squares
  localparam int LEN_W       = 31;              // saturated length
  localparam int ITERS       = 32;              // bit pairs in the sum
  localparam int ITER_W      = $clog2(ITERS);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [SUM_W-1:0] PLACE_INIT = SUM_W'(1) << (SUM_W - 2);
  localparam logic [LEN_W-1:0] LEN_MAX    = {LEN_W{1'b1}};

  // front -> queue transfer
  typedef struct packed {
    logic             valid;
    logic [SUM_W-1:0] sum;
  } vli_item_t;

endpackage

/* design/vli_front.sv */
// ----------------------------------------------------------------------------
// vli_front
// Takes a command, forms the component magnitudes and the sum of squares
// on one shared 32x32 multiplier, then hands the sum to the queue.
// ----------------------------------------------------------------------------
module vli_front
  import vli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COMP_W-1:0] x_component,
  input  logic signed [COMP_W-1:0] y_component,
  output vli_item_t                push,
  input  logic                     push_ready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SQX  = 2'd1;
  localparam logic [1:0] S_SQY  = 2'd2;
  localparam logic [1:0] S_ADD  = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [SUM_W-1:0] prod;
  logic [SUM_W-1:0] sum;
  logic [MAG_W-1:0] mul_op;

  assign busy = (state != S_IDLE);

  // two's complement negate; -2^31 comes out as 2^31 unsigned
  function automatic logic [MAG_W-1:0] magnitude(input logic [COMP_W-1:0] v);
    logic [MAG_W-1:0] r;
    r = v[COMP_W-1] ? MAG_W'(~v + 1'b1) : MAG_W'(v);
    return r;
  endfunction

  assign mul_op = (state == S_SQX) ? mag_x : mag_y;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (start) state_next = S_SQX;
      S_SQX:  state_next = S_SQY;
      S_SQY:  state_next = S_ADD;
      S_ADD:  if (push_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      mag_x <= magnitude(x_component);
      mag_y <= magnitude(y_component);
    end
    if (state == S_SQX || state == S_SQY) begin
      prod <= SUM_W'(mul_op) * SUM_W'(mul_op);
    end
    if (state == S_SQY) begin
      sum <= prod;
    end
  end

  // both squares are below 2^62+1, so the sum cannot overflow 64 bits
  assign push.valid = (state == S_ADD);
  assign push.sum   = sum + prod;

endmodule

/* design/vli_queue.sv */
// ----------------------------------------------------------------------------
// vli_queue
// Short FIFO of sums between the front and the root unit.
// ----------------------------------------------------------------------------
module vli_queue
  import vli_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  vli_item_t push,
  output logic      push_ready,
  output vli_item_t head,
  input  logic      pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [SUM_W-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.sum   = slots[rptr];

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= bump(wptr);
      if (do_pop)  rptr <= bump(rptr);
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push.sum;
  end

endmodule

/* design/vli_back.sv */
// ----------------------------------------------------------------------------
// vli_back
// Digit-by-digit square root: one bit pair per cycle on a shared
// subtract-compare, then saturation to the 31-bit length.
// ----------------------------------------------------------------------------
module vli_back
  import vli_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  vli_item_t        head,
  output logic             pop,
  output logic             done,
  output logic [LEN_W-1:0] length,
  output logic             saturated
);

  logic              running;
  logic [ITER_W-1:0] iter;
  logic [SUM_W-1:0]  rem;
  logic [SUM_W-1:0]  root;
  logic [SUM_W-1:0]  place;
  logic [SUM_W-1:0]  trial;
  logic              take;
  logic [SUM_W-1:0]  rem_next;
  logic [SUM_W-1:0]  root_next;
  logic              last;
  logic              over;

  assign pop  = !running && head.valid;
  assign last = (iter == ITER_W'(ITERS - 1));

  assign trial     = root + place;
  assign take      = (rem >= trial);
  assign rem_next  = take ? rem - trial : rem;
  assign root_next = (take ? trial + place : root) >> 1;
  // final root fits in 32 bits; anything at bit LEN_W or above saturates
  assign over      = |root_next[SUM_W-1:LEN_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= running && last;
      if (pop) begin
        running <= 1'b1;
      end else if (running && last) begin
        running <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rem   <= head.sum;
      root  <= '0;
      place <= PLACE_INIT;
      iter  <= '0;
    end else if (running) begin
      rem   <= rem_next;
      root  <= root_next;
      place <= place >> 2;
      iter  <= iter + 1'b1;
    end
    if (running && last) begin
      length    <= over ? LEN_MAX : root_next[LEN_W-1:0];
      saturated <= over;
    end
  end

endmodule

/* design/vector_length_isqrt.sv */
// ----------------------------------------------------------------------------
// vector_length_isqrt
// Euclidean length of a signed 16.16 vector: exact sum of squares, then a
// truncated integer square root, saturated to 31 bits.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  command   start / busy     x_component, y_component
//  result    done (strobe)    length, saturated
//
//  A command passes through the front (one multiplier, used twice) and
//  then the root unit (32 bit-pair steps); the root unit takes no new sum
//  until it is through with the last one, so it sets the sustained rate.
//  busy is high while the front holds a command, and longer when the queue
//  ahead of the root unit is full. The receiver cannot stall: done is high
//  for one cycle per result. Reset is synchronous and empties everything.
// ----------------------------------------------------------------------------
module vector_length_isqrt
  import vli_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [COMP_W-1:0] x_component,
  input  logic signed [COMP_W-1:0] y_component,
  output logic                     done,
  output logic [LEN_W-1:0]         length,
  output logic                     saturated
);

  vli_item_t push;
  vli_item_t head;
  logic      push_ready;
  logic      pop;

  vli_front u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .x_component (x_component),
    .y_component (y_component),
    .push        (push),
    .push_ready  (push_ready)
  );

  vli_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .head       (head),
    .pop        (pop)
  );

  vli_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .done      (done),
    .length    (length),
    .saturated (saturated)
  );

endmodule

/* design/vli_checker.sv */
// ----------------------------------------------------------------------------
// vli_checker
// Port-level checks on the vector length unit, bound to the top level.
// ----------------------------------------------------------------------------
module vli_checker
  import vli_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             done,
  input logic [LEN_W-1:0] length,
  input logic             saturated
);

  // nothing left in flight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !done && !busy)
    else $error("done or busy set right after reset");

  // an accepted command keeps the front occupied for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after a command transfer");

  // the root unit takes no new sum until it is through with the last, so strobes never abut
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobes in consecutive cycles");

  // a saturated result carries the largest length
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    done && saturated |-> length == LEN_MAX)
    else $error("saturated result without maximum length");

endmodule

bind vector_length_isqrt vli_checker u_vli_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .length    (length),
  .saturated (saturated)
);
